// ===== src/ray_disk_intersect_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ray / disk intersection block
// Each macro names an assertion clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RAY_DISK_INTERSECT_TOP_ASSERT_SVH
`define RAY_DISK_INTERSECT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define RDI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdi assertion failed");
// Next-cycle implication.
`define RDI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdi assertion failed");
`else
`define RDI_ASSERT_IMP(label, ante, cons)
`define RDI_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== src/rdi_pkg.sv =====
// ----------------------------------------------------------------------------
// rdi_pkg
// Widths, register indexes and payload types of the ray / disk intersection.
// ----------------------------------------------------------------------------
package rdi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int W      = COORD_WIDTH;
  localparam int DIFF_W = W + 1;           // centre minus origin
  localparam int PROD_W = 2 * W + 1;       // difference times normal
  localparam int NUM_W  = PROD_W + 2;      // sum of three such products
  localparam int DEN_W  = 2 * W + 2;       // sum of three direction products
  localparam int DVD_W  = NUM_W + FRAC_BITS;
  localparam int EPS_RESET = ((1 << FRAC_BITS) + 500) / 1000;

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W - 1){1'b0}}};

  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_NORMAL_X,
    REG_NORMAL_Y,
    REG_NORMAL_Z,
    REG_RADIUS,
    REG_MIN_DISTANCE
  } reg_idx_t;

  typedef struct packed {
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] origin_z;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
    logic signed [W-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic                is_hit;
    logic signed [W-1:0] distance;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;
  } out_t;

  typedef struct packed {
    logic signed [W-1:0] center_x;
    logic signed [W-1:0] center_y;
    logic signed [W-1:0] center_z;
    logic signed [W-1:0] normal_x;
    logic signed [W-1:0] normal_y;
    logic signed [W-1:0] normal_z;
    logic        [W-2:0] radius;
    logic        [W-2:0] min_distance;
  } cfg_t;

  // Side information that travels with a ray through the divider.
  typedef struct packed {
    in_t  ray;
    logic neg;
    logic den_zero;
  } ray_sb_t;

endpackage

// ===== src/rdi_front.sv =====
// ----------------------------------------------------------------------------
// rdi_front
// Plane numerator and denominator, split into sign and magnitude.
// ----------------------------------------------------------------------------
module rdi_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             ray_valid,
  input  rdi_pkg::in_t     ray,
  input  rdi_pkg::cfg_t    cfg,
  output logic             div_valid,
  output logic [rdi_pkg::DVD_W-1:0] dvd,
  output logic [rdi_pkg::DEN_W-1:0] dsr,
  output rdi_pkg::ray_sb_t sb
);
  localparam int W  = rdi_pkg::W;
  localparam int XW = rdi_pkg::DIFF_W;
  localparam int PW = rdi_pkg::PROD_W;
  localparam int NW = rdi_pkg::NUM_W;
  localparam int DW = rdi_pkg::DEN_W;
  localparam int F  = rdi_pkg::FRAC_BITS;

  logic signed [W-1:0]  cen [3];
  logic signed [W-1:0]  nrm [3];
  logic signed [W-1:0]  org [3];
  logic signed [W-1:0]  dir1 [3];
  logic signed [XW-1:0] diff_next [3];

  logic                 v1, v2, v3;
  rdi_pkg::in_t         ray1, ray2, ray3;
  logic signed [XW-1:0] diff1 [3];
  logic signed [PW-1:0] np2 [3];
  logic signed [2*W-1:0] dp2 [3];
  logic signed [NW-1:0] num3;
  logic signed [DW-1:0] den3;
  logic signed [NW-1:0] num_neg;
  logic signed [DW-1:0] den_neg;

  always_comb begin
    cen[0] = cfg.center_x;  cen[1] = cfg.center_y;  cen[2] = cfg.center_z;
    nrm[0] = cfg.normal_x;  nrm[1] = cfg.normal_y;  nrm[2] = cfg.normal_z;
    org[0] = ray.origin_x;  org[1] = ray.origin_y;  org[2] = ray.origin_z;
    dir1[0] = ray1.dir_x;   dir1[1] = ray1.dir_y;   dir1[2] = ray1.dir_z;
    for (int i = 0; i < 3; i++) begin
      diff_next[i] = XW'(cen[i]) - XW'(org[i]);
    end
    num_neg = -num3;
    den_neg = -den3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      div_valid <= 1'b0;
    end else if (adv) begin
      v1 <= ray_valid;
      v2 <= v1;
      v3 <= v2;
      div_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray1 <= ray;
      ray2 <= ray1;
      ray3 <= ray2;
      for (int i = 0; i < 3; i++) begin
        diff1[i] <= diff_next[i];
        np2[i]   <= diff1[i] * nrm[i];
        dp2[i]   <= dir1[i] * nrm[i];
      end
      num3 <= NW'(np2[0]) + NW'(np2[1]) + NW'(np2[2]);
      den3 <= DW'(dp2[0]) + DW'(dp2[1]) + DW'(dp2[2]);
      dvd  <= {(num3[NW-1] ? num_neg : num3), {F{1'b0}}};
      dsr  <= den3[DW-1] ? den_neg : den3;
      sb.ray      <= ray3;
      sb.neg      <= num3[NW-1] ^ den3[DW-1];
      sb.den_zero <= (den3 == '0);
    end
  end

endmodule

// ===== src/rdi_div.sv =====
// ----------------------------------------------------------------------------
// rdi_div
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module rdi_div #(
  parameter int DVD_W = rdi_pkg::DVD_W,
  parameter int DEN_W = rdi_pkg::DEN_W,
  parameter int SB_W  = $bits(rdi_pkg::ray_sb_t)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [DVD_W-1:0] in_dvd,
  input  logic [DEN_W-1:0] in_dsr,
  input  logic [SB_W-1:0]  in_sb,
  output logic             quo_valid,
  output logic [DVD_W-1:0] quo,
  output logic [SB_W-1:0]  quo_sb
);
  localparam int N = DVD_W;

  // The dividend shifts out at the top while quotient bits shift in below.
  // Index k holds the registered output of stage k.
  logic             v   [N];
  logic [DEN_W-1:0] rem [N];
  logic [DVD_W-1:0] acc [N];
  logic [DEN_W-1:0] dsr [N];
  logic [SB_W-1:0]  sb  [N];

  logic             v_in   [N];
  logic [DEN_W-1:0] rem_in [N];
  logic [DVD_W-1:0] acc_in [N];
  logic [DEN_W-1:0] dsr_in [N];
  logic [SB_W-1:0]  sb_in  [N];

  logic [DEN_W:0]   trial [N];
  logic [DEN_W:0]   dif   [N];
  logic [DEN_W-1:0] rem_next [N];
  logic             qbit [N];

  always_comb begin
    v_in[0]   = in_valid;
    rem_in[0] = '0;
    acc_in[0] = in_dvd;
    dsr_in[0] = in_dsr;
    sb_in[0]  = in_sb;
    for (int k = 1; k < N; k++) begin
      v_in[k]   = v[k-1];
      rem_in[k] = rem[k-1];
      acc_in[k] = acc[k-1];
      dsr_in[k] = dsr[k-1];
      sb_in[k]  = sb[k-1];
    end
    for (int k = 0; k < N; k++) begin
      trial[k] = {rem_in[k], acc_in[k][DVD_W-1]};
      dif[k]   = trial[k] - {1'b0, dsr_in[k]};
      qbit[k]  = (trial[k] >= {1'b0, dsr_in[k]});
      rem_next[k] = qbit[k] ? dif[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) v[k] <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < N; k++) v[k] <= v_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        rem[k] <= rem_next[k];
        acc[k] <= {acc_in[k][DVD_W-2:0], qbit[k]};
        dsr[k] <= dsr_in[k];
        sb[k]  <= sb_in[k];
      end
    end
  end

  assign quo_valid = v[N-1];
  assign quo       = acc[N-1];
  assign quo_sb    = sb[N-1];

endmodule

// ===== src/rdi_back.sv =====
// ----------------------------------------------------------------------------
// rdi_back
// Saturates t, forms the hit point and runs the epsilon and radius tests.
// ----------------------------------------------------------------------------
module rdi_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             quo_valid,
  input  logic [rdi_pkg::DVD_W-1:0] quo,
  input  rdi_pkg::ray_sb_t sb,
  input  rdi_pkg::cfg_t    cfg,
  output logic             res_valid,
  output rdi_pkg::out_t    res
);
  localparam int W  = rdi_pkg::W;
  localparam int F  = rdi_pkg::FRAC_BITS;
  localparam int QW = rdi_pkg::DVD_W;
  localparam int PW = 2 * W + 1;
  localparam int SW = 2 * W + 2;
  localparam int LW = 2 * W + 4;

  logic signed [W-1:0]   t_next;
  logic                  hi_nz;
  logic                  sat;

  logic                  v5, v6, v7, v8;
  rdi_pkg::ray_sb_t      sb5, sb6, sb7, sb8;
  logic signed [W-1:0]   t5, t6, t7, t8;
  logic                  eps5, eps6, eps7, eps8;
  logic signed [2*W-1:0] prod6 [3];
  logic signed [W-1:0]   pt7 [3];
  logic signed [W-1:0]   pt8 [3];
  logic        [SW-1:0]  sq8 [3];
  logic        [2*W-3:0] rsq;

  logic signed [W-1:0]   dir5 [3];
  logic signed [W-1:0]   org6 [3];
  logic signed [W-1:0]   cen [3];
  logic signed [PW-1:0]  p_next [3];
  logic signed [W-1:0]   pt_next [3];
  logic signed [W:0]     dd [3];
  logic        [LW-1:0]  len;
  logic                  in_disk;

  always_comb begin
    hi_nz = |quo[QW-1:W];
    if (!sb.neg) begin
      sat    = hi_nz | quo[W-1];
      t_next = sat ? rdi_pkg::SMAX : quo[W-1:0];
    end else begin
      sat    = hi_nz | (quo[W-1] & (|quo[W-2:0]));
      t_next = sat ? rdi_pkg::SMIN : -quo[W-1:0];
    end

    dir5[0] = sb5.ray.dir_x;     dir5[1] = sb5.ray.dir_y;     dir5[2] = sb5.ray.dir_z;
    org6[0] = sb6.ray.origin_x;  org6[1] = sb6.ray.origin_y;  org6[2] = sb6.ray.origin_z;
    cen[0]  = cfg.center_x;      cen[1]  = cfg.center_y;      cen[2]  = cfg.center_z;
    for (int i = 0; i < 3; i++) begin
      p_next[i] = PW'(prod6[i] >>> F) + PW'(org6[i]);
      if (p_next[i][PW-1:W-1] == '0 || p_next[i][PW-1:W-1] == '1) begin
        pt_next[i] = p_next[i][W-1:0];
      end else begin
        pt_next[i] = p_next[i][PW-1] ? rdi_pkg::SMIN : rdi_pkg::SMAX;
      end
      dd[i] = (W + 1)'(pt7[i]) - (W + 1)'(cen[i]);
    end
    len     = LW'(sq8[0]) + LW'(sq8[1]) + LW'(sq8[2]);
    in_disk = !(len > LW'(rsq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v5 <= quo_valid;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      res_valid <= v8;
    end
  end

  // Squared radius follows the register; the user changes it only while idle.
  always_ff @(posedge clk) begin
    rsq <= cfg.radius * cfg.radius;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb5  <= sb;
      t5   <= t_next;
      // A positive quotient beyond the coordinate range is above any epsilon.
      eps5 <= (sat & ~sb.neg) | (t_next > $signed({1'b0, cfg.min_distance}));
      sb6 <= sb5;  t6 <= t5;  eps6 <= eps5;
      sb7 <= sb6;  t7 <= t6;  eps7 <= eps6;
      sb8 <= sb7;  t8 <= t7;  eps8 <= eps7;
      for (int i = 0; i < 3; i++) begin
        prod6[i] <= dir5[i] * t5;
        pt7[i]   <= pt_next[i];
        pt8[i]   <= pt7[i];
        sq8[i]   <= SW'(dd[i] * dd[i]);
      end
      res.is_hit   <= eps8 & in_disk & ~sb8.den_zero;
      res.distance <= sb8.den_zero ? rdi_pkg::SMAX : t8;
      res.point_x  <= sb8.den_zero ? '0 : pt8[0];
      res.point_y  <= sb8.den_zero ? '0 : pt8[1];
      res.point_z  <= sb8.den_zero ? '0 : pt8[2];
    end
  end

endmodule

// ===== src/ray_disk_intersect_top.sv =====
// ----------------------------------------------------------------------------
// ray_disk_intersect_top
// Streaming ray against configured disk intersection test in fixed point.
// ----------------------------------------------------------------------------
// One ray enters per clock while the output is not stalled, and one result
// leaves per clock for each ray. The default format is Q16.16. Four stages
// form the plane numerator and denominator, the exact quotient comes from a
// restoring divider that retires one bit per stage, and five stages saturate
// t, build the hit point and run the radius test. Back-pressure on the output
// stalls the whole pipeline in place, so a stalled beat is neither lost nor
// repeated. Registers are written through cfg_write, cfg_index and cfg_data,
// and should only be written while no ray is in flight. A ray parallel to the
// plane reports a miss with the largest positive distance and a zero point;
// otherwise distance and point carry the plane values even on a miss.
// ----------------------------------------------------------------------------
`include "ray_disk_intersect_top_assert.svh"

module ray_disk_intersect_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [rdi_pkg::W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rdi_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rdi_pkg::out_t             out_data
);
  localparam int W = rdi_pkg::W;

  rdi_pkg::cfg_t    cfg;
  logic             adv;
  logic             dv_valid;
  logic [rdi_pkg::DVD_W-1:0] dv_dvd;
  logic [rdi_pkg::DEN_W-1:0] dv_dsr;
  rdi_pkg::ray_sb_t dv_sb;
  logic             q_valid;
  logic [rdi_pkg::DVD_W-1:0] q_quo;
  logic [$bits(rdi_pkg::ray_sb_t)-1:0] q_sb;

  // The pipeline moves whenever the output beat is taken or absent.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x     <= '0;
      cfg.center_y     <= '0;
      cfg.center_z     <= '0;
      cfg.normal_x     <= '0;
      cfg.normal_y     <= W'(1 << rdi_pkg::FRAC_BITS);
      cfg.normal_z     <= '0;
      cfg.radius       <= (W - 1)'(1 << rdi_pkg::FRAC_BITS);
      cfg.min_distance <= (W - 1)'(rdi_pkg::EPS_RESET);
    end else if (cfg_write) begin
      case (rdi_pkg::reg_idx_t'(cfg_index))
        rdi_pkg::REG_CENTER_X:     cfg.center_x     <= cfg_data;
        rdi_pkg::REG_CENTER_Y:     cfg.center_y     <= cfg_data;
        rdi_pkg::REG_CENTER_Z:     cfg.center_z     <= cfg_data;
        rdi_pkg::REG_NORMAL_X:     cfg.normal_x     <= cfg_data;
        rdi_pkg::REG_NORMAL_Y:     cfg.normal_y     <= cfg_data;
        rdi_pkg::REG_NORMAL_Z:     cfg.normal_z     <= cfg_data;
        rdi_pkg::REG_RADIUS:       cfg.radius       <= cfg_data[W-2:0];
        rdi_pkg::REG_MIN_DISTANCE: cfg.min_distance <= cfg_data[W-2:0];
        default: begin
        end
      endcase
    end
  end

  rdi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ray_valid (in_valid),
    .ray       (in_data),
    .cfg       (cfg),
    .div_valid (dv_valid),
    .dvd       (dv_dvd),
    .dsr       (dv_dsr),
    .sb        (dv_sb)
  );

  rdi_div #(
    .DVD_W (rdi_pkg::DVD_W),
    .DEN_W (rdi_pkg::DEN_W),
    .SB_W  ($bits(rdi_pkg::ray_sb_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (dv_valid),
    .in_dvd    (dv_dvd),
    .in_dsr    (dv_dsr),
    .in_sb     (dv_sb),
    .quo_valid (q_valid),
    .quo       (q_quo),
    .quo_sb    (q_sb)
  );

  rdi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .quo_valid (q_valid),
    .quo       (q_quo),
    .sb        (rdi_pkg::ray_sb_t'(q_sb)),
    .cfg       (cfg),
    .res_valid (out_valid),
    .res       (out_data)
  );

  // A hit lies beyond a non-negative epsilon, so its distance is positive.
  `RDI_ASSERT_IMP(a_hit_positive, out_valid && out_data.is_hit, !out_data.distance[W-1])
  // A stalled pipeline holds the valid flags at its divider input and output in place.
  `RDI_ASSERT_NXT(a_stall_holds, !adv, $stable(dv_valid) && $stable(q_valid))
  // A stalled result beat stays offered and unchanged.
  `RDI_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule
